// ===== hw/rtl/radix_number_to_ascii_core_assert.svh =====
// Assertion macros shared by the RTL of the number-to-ASCII core.
// Each macro checks on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef RADIX_NUMBER_TO_ASCII_CORE_ASSERT_SVH
`define RADIX_NUMBER_TO_ASCII_CORE_ASSERT_SVH

// Same-cycle implication
`define RNA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RNA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rna_pkg.sv =====
`timescale 1ns / 1ps

package rna_pkg;

    // Default sizing
    localparam int MAX_WIDTH_DEF   = 63;
    localparam int DIGIT_SLOTS_DEF = 12;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;
    localparam int WIDTH_W = 6;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    // Radix commands
    localparam logic [CMD_W-1:0] CMD_DEC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OCT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HEX = 2'd2;

    // Reciprocal of ten, scaled by 2^35
    localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_ALPHA = 7'h37;   // 'A' - 10

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Sequencer to digit unit
    typedef struct packed {
        logic load;
        logic neg;
        logic mul;
        logic step;
    } t_du_ctrl;

    // Digit unit to sequencer
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } t_du_stat;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            return ASCII_ZERO + dx;
        end else begin
            return ASCII_ALPHA + dx;
        end
    endfunction

endpackage

// ===== hw/rtl/rna_digit_unit.sv =====
`timescale 1ns / 1ps

module rna_digit_unit (
    input  logic                           i_clk,
    input  logic [rna_pkg::VALUE_W-1:0]    i_value,
    input  logic [rna_pkg::CMD_W-1:0]      i_mode,
    input  rna_pkg::t_du_ctrl              i_ctrl,
    output rna_pkg::t_du_stat              o_stat
);

    localparam int PW = 2 * rna_pkg::VALUE_W;
    localparam int QW = PW - rna_pkg::RECIP_SHIFT;

    logic [rna_pkg::VALUE_W-1:0] r_mag;
    logic [rna_pkg::VALUE_W-1:0] n_mag;
    logic [rna_pkg::CMD_W-1:0]   r_mode;
    logic [QW-1:0]               r_prod;

    logic [rna_pkg::VALUE_W-1:0] quot;
    logic [rna_pkg::DIGIT_W-1:0] digit;
    logic [rna_pkg::DIGIT_W-1:0] q10_lo;

    // Split off one digit and the remaining magnitude
    always_comb begin
        q10_lo = '0;
        case (r_mode)
            rna_pkg::CMD_DEC: begin
                quot   = {{(rna_pkg::VALUE_W-QW){1'b0}}, r_prod};
                q10_lo = 4'(quot[3:0] << 3) + 4'(quot[3:0] << 1);
                digit  = r_mag[3:0] - q10_lo;
            end
            rna_pkg::CMD_OCT: begin
                quot  = r_mag >> 3;
                digit = {1'b0, r_mag[2:0]};
            end
            default: begin
                quot  = r_mag >> 4;
                digit = r_mag[3:0];
            end
        endcase
    end

    // Load the magnitude, negating a negative decimal value, or step it down to the quotient
    always_comb begin
        n_mag = r_mag;
        if (i_ctrl.load) begin
            n_mag = i_ctrl.neg ? (rna_pkg::VALUE_W'(0) - i_value) : i_value;
        end else if (i_ctrl.step) begin
            n_mag = quot;
        end
    end

    // Hold magnitude, mode and the scaled quotient
    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        if (i_ctrl.load) begin
            r_mode <= i_mode;
        end
        if (i_ctrl.mul) begin
            r_prod <= QW'((PW'(r_mag) * PW'(rna_pkg::RECIP10)) >> rna_pkg::RECIP_SHIFT);
        end
    end

    assign o_stat.digit      = digit;
    assign o_stat.last_digit = (quot == '0);

endmodule

// ===== hw/rtl/radix_number_to_ascii_core.sv =====
`timescale 1ns / 1ps

// Number-to-ASCII converter: one request (a 32-bit value in tdata[31:0], field width in
// tdata[37:32], radix in tuser) becomes a run of ASCII characters, most significant first,
// right-justified with spaces to the field width and closed by tlast. A shared digit unit
// peels one digit per step: decimal needs a reciprocal multiply and then a remainder step
// for each digit, octal and hex need one step. A request is loaded, the digits are peeled,
// the padding is sized, then one character goes out per cycle while the sink keeps tready high.
// The core takes a new request only once the last character of the run has been issued.
module radix_number_to_ascii_core #(
    parameter int MAX_WIDTH   = rna_pkg::MAX_WIDTH_DEF,
    parameter int DIGIT_SLOTS = rna_pkg::DIGIT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,    // value[31:0], width[37:32], zero fill
    input  logic [1:0]  i_s_axis_tuser,    // cmd[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,    // char_out[6:0], zero fill
    output logic        o_m_axis_tlast     // last
);

    localparam int NW = $clog2(DIGIT_SLOTS + 1);
    localparam int IW = $clog2(DIGIT_SLOTS);
    localparam int WW = rna_pkg::WIDTH_W;

    rna_pkg::t_state   r_state;
    rna_pkg::t_state   n_state;
    rna_pkg::t_du_ctrl du_ctrl;
    rna_pkg::t_du_stat du_stat;

    logic [rna_pkg::DIGIT_W-1:0] r_dig [DIGIT_SLOTS];
    logic [NW-1:0]               r_n;
    logic [NW-1:0]               r_idx;
    logic [WW-1:0]               r_width;
    logic [WW-1:0]               r_pad;
    logic                        r_neg;
    logic                        r_dec;

    logic                        r_m_tvalid;
    logic [rna_pkg::CHAR_W-1:0]  r_m_char;
    logic                        r_m_last;

    logic [rna_pkg::VALUE_W-1:0] in_value;
    logic [WW-1:0]               in_width;
    logic [rna_pkg::CMD_W-1:0]   in_cmd;
    logic                        in_neg;
    logic                        accept;
    logic                        slot_free;
    logic                        load_out;
    logic [rna_pkg::CHAR_W-1:0]  out_char;
    logic                        out_last;
    logic [NW-1:0]               idx_m1;
    logic [WW-1:0]               total;

    assign in_value = i_s_axis_tdata[31:0];
    assign in_width = i_s_axis_tdata[37:32];
    assign in_cmd   = i_s_axis_tuser;
    assign in_neg   = (in_cmd == rna_pkg::CMD_DEC) && in_value[31];

    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_m_tvalid || i_m_axis_tready;
    assign idx_m1    = r_idx - NW'(1);
    assign total     = WW'(r_n) + WW'(r_neg);

    rna_digit_unit u_digit (
        .i_clk   (i_clk),
        .i_value (in_value),
        .i_mode  (in_cmd),
        .i_ctrl  (du_ctrl),
        .o_stat  (du_stat)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rna_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (in_cmd == rna_pkg::CMD_DEC) ? rna_pkg::ST_MUL : rna_pkg::ST_DIG;
                end
            end
            rna_pkg::ST_MUL: n_state = rna_pkg::ST_DIG;
            rna_pkg::ST_DIG: begin
                if (du_stat.last_digit) begin
                    n_state = rna_pkg::ST_PAD;
                end else begin
                    n_state = r_dec ? rna_pkg::ST_MUL : rna_pkg::ST_DIG;
                end
            end
            rna_pkg::ST_PAD: n_state = rna_pkg::ST_EMIT;
            rna_pkg::ST_EMIT: begin
                if (load_out && out_last) begin
                    n_state = rna_pkg::ST_IDLE;
                end
            end
            default: n_state = rna_pkg::ST_IDLE;
        endcase
    end

    // Control outputs and next character
    always_comb begin
        o_s_axis_tready = 1'b0;
        du_ctrl         = '0;
        load_out        = 1'b0;
        out_char        = rna_pkg::digit_to_ascii(r_dig[idx_m1[IW-1:0]]);
        out_last        = 1'b0;
        case (r_state)
            rna_pkg::ST_IDLE: begin
                // hold off requests while reset is applied
                o_s_axis_tready = i_rst_n;
                du_ctrl.load    = accept;
                du_ctrl.neg     = in_neg;
            end
            rna_pkg::ST_MUL: du_ctrl.mul = 1'b1;
            rna_pkg::ST_DIG: du_ctrl.step = 1'b1;
            rna_pkg::ST_EMIT: begin
                load_out = slot_free;
                if (r_pad != '0) begin
                    out_char = rna_pkg::ASCII_SPACE;
                end else if (r_neg) begin
                    out_char = rna_pkg::ASCII_MINUS;
                end else begin
                    out_last = (r_idx == NW'(1));
                end
            end
            default: ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rna_pkg::ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            rna_pkg::ST_IDLE: begin
                if (accept) begin
                    r_neg   <= in_neg;
                    r_dec   <= (in_cmd == rna_pkg::CMD_DEC);
                    r_n     <= '0;
                    r_width <= (in_width > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : in_width;
                end
            end
            rna_pkg::ST_DIG: begin
                // store the digit while a slot is left, drop it otherwise
                if (r_n < NW'(DIGIT_SLOTS)) begin
                    r_dig[r_n[IW-1:0]] <= du_stat.digit;
                    r_n                <= r_n + NW'(1);
                end
            end
            rna_pkg::ST_PAD: begin
                r_pad <= (r_width > total) ? (r_width - total) : '0;
                r_idx <= r_n;
            end
            rna_pkg::ST_EMIT: begin
                if (load_out) begin
                    if (r_pad != '0) begin
                        r_pad <= r_pad - WW'(1);
                    end else if (r_neg) begin
                        r_neg <= 1'b0;
                    end else begin
                        r_idx <= idx_m1;
                    end
                end
            end
            default: ;
        endcase
        if (load_out) begin
            r_m_char <= out_char;
            r_m_last <= out_last;
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = {1'b0, r_m_char};
    assign o_m_axis_tlast  = r_m_last;

`include "radix_number_to_ascii_core_assert.svh"

    `RNA_ASSERT_SAME(a_emit_has_digit, (r_state == rna_pkg::ST_EMIT), (r_idx != '0), "emit with no digit left")
    `RNA_ASSERT_SAME(a_count_in_range, (r_state == rna_pkg::ST_PAD), ((r_n != '0) && (r_n <= NW'(DIGIT_SLOTS))), "digit count out of range")
    `RNA_ASSERT_NEXT(a_last_ends_run, (load_out && out_last), ((r_state == rna_pkg::ST_IDLE) && o_m_axis_tvalid && o_m_axis_tlast), "run did not close on last")

endmodule
